// ===== rtl/vbd_pkg.sv =====
`default_nettype none
package vbd_pkg;

   localparam int unsigned MaxBatch = 256;
   localparam logic [16:0] MaxBatchLimit = 17'(MaxBatch);

   localparam logic [8:0] MaxValuesReset = 9'd256;
   localparam logic [10:0] CommitMax = 11'd2047;
   localparam logic [2:0] LastPosition = 3'd4;

   typedef enum logic [1:0] {
      STATUS_COMPLETE  = 2'd0,
      STATUS_TRUNCATED = 2'd1,
      STATUS_LIMIT     = 2'd2,
      STATUS_MALFORMED = 2'd3
   } status_type;

   typedef struct packed {
      logic [10:0] consumed_bytes;
      logic [8:0]  value_count;
      status_type  status;
      logic [31:0] value;
      logic        value_valid;
      logic        batch_done;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/varint_batch_decoder_core.sv =====
// A result is registered into the main output entry, or into the skid entry while
// the main entry still holds one. Throughput: one byte per cycle unless the skid
// entry is full; the per-byte accumulate, shift and compare are combinational and a
// two-entry output buffer keeps req_tready up while one result waits on rsp_tready.
// Reset (synchronous, active high) clears the batch state and the output buffer
// and sets max_values to 256.
`default_nettype none
module varint_batch_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [8:0]  csr_wdata,   // max_values
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte[7:0]
   input  wire logic        req_tlast,   // end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // value[31:0], status[33:32],
                                         // value_count[42:34], consumed_bytes[53:43], zeros
   output logic             rsp_tuser,   // value_valid
   output logic             rsp_tlast    // batch_done
);
   import vbd_pkg::*;

   logic [8:0]  max_values_ff;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  pos_ff, pos_in;
   logic [8:0]  count_ff, count_in;
   logic [10:0] commit_ff, commit_in;
   logic        halted_ff, halted_in;
   status_type  reason_ff, reason_in;

   rsp_type     main_ff, skid_ff, result;
   logic        main_valid_ff, skid_valid_ff;

   logic [16:0] limit;
   logic        accept, emit, pop;
   logic [31:0] piece, acc_or;
   logic [11:0] commit_sum;
   logic [6:0]  bits7;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign bits7      = req_tdata[6:0];

   assign limit = ({8'b0, max_values_ff} > MaxBatchLimit) ? MaxBatchLimit
                                                          : {8'b0, max_values_ff};

   always_comb begin
      unique case (pos_ff)
         3'd0:    piece = {25'b0, bits7};
         3'd1:    piece = {18'b0, bits7, 7'b0};
         3'd2:    piece = {11'b0, bits7, 14'b0};
         3'd3:    piece = {4'b0, bits7, 21'b0};
         default: piece = {bits7[3:0], 28'b0};
      endcase
   end

   assign acc_or     = acc_ff | piece;
   assign commit_sum = {1'b0, commit_ff} + {9'b0, pos_ff} + 12'd1;

   always_comb begin
      acc_in    = acc_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      commit_in = commit_ff;
      halted_in = halted_ff;
      reason_in = reason_ff;
      result    = '0;
      if (!halted_ff) begin
         if ({8'b0, count_ff} >= limit) begin
            halted_in = 1'b1;
            reason_in = STATUS_LIMIT;
         end else if (!req_tdata[7]) begin
            result.value       = acc_or;
            result.value_valid = 1'b1;
            count_in  = count_ff + 9'd1;
            commit_in = commit_sum[11] ? CommitMax : commit_sum[10:0];
            acc_in    = '0;
            pos_in    = '0;
            if ({8'b0, count_in} >= limit) begin
               halted_in = 1'b1;
               reason_in = STATUS_LIMIT;
            end
         end else if (pos_ff == LastPosition) begin
            acc_in    = '0;
            pos_in    = '0;
            halted_in = 1'b1;
            reason_in = STATUS_MALFORMED;
         end else begin
            acc_in = acc_or;
            pos_in = pos_ff + 3'd1;
         end
      end
      if (req_tlast) begin
         result.batch_done     = 1'b1;
         result.value_count    = count_in;
         result.consumed_bytes = commit_in;
         if (halted_in) begin
            result.status = reason_in;
         end else if (pos_in != 3'd0) begin
            result.status = STATUS_TRUNCATED;
         end else begin
            result.status = STATUS_COMPLETE;
         end
         acc_in    = '0;
         pos_in    = '0;
         count_in  = '0;
         commit_in = '0;
         halted_in = 1'b0;
         reason_in = STATUS_COMPLETE;
      end
   end

   assign emit = result.value_valid || result.batch_done;
   assign pop  = main_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_values_ff <= MaxValuesReset;
      end else if (csr_we) begin
         max_values_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         pos_ff    <= '0;
         count_ff  <= '0;
         commit_ff <= '0;
         halted_ff <= 1'b0;
         reason_ff <= STATUS_COMPLETE;
      end else if (accept) begin
         acc_ff    <= acc_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         commit_ff <= commit_in;
         halted_ff <= halted_in;
         reason_ff <= reason_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= accept && emit;
         end
      end else if (accept && emit) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!main_valid_ff || pop) begin
         main_ff <= skid_valid_ff ? skid_ff : result;
      end
      if (main_valid_ff && !pop && accept && emit) begin
         skid_ff <= result;
      end
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {2'b0, main_ff.consumed_bytes, main_ff.value_count,
                        main_ff.status, main_ff.value};
   assign rsp_tuser  = main_ff.value_valid;
   assign rsp_tlast  = main_ff.batch_done;

endmodule
`default_nettype wire
